### sv/dpft_pkg.sv
package dpft_pkg;

    // Sizing
    localparam int PAGES          = 32;
    localparam int PAGE_BYTES     = 4096;
    localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
    localparam int ADDR_W         = 48;
    localparam int REGION_PAGES_W = 6;
    localparam int IDX_W          = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CNT_W          = $clog2(PAGES + 1);
    localparam int ACTION_W       = 3;
    localparam int PAGE_W         = 5;

    // Queue depths (powers of two)
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
    localparam int RQ_DEPTH = 2;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_PAGES = 1'd1;

    // Input commands
    localparam logic CMD_FAULT = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Result actions
    localparam logic [ACTION_W-1:0] ACT_FETCH     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_GRANT     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CHAIN     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WRITEBACK = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DONE      = 3'd4;

    // Classified command kinds
    localparam logic [1:0] KIND_FAULT = 2'd0;
    localparam logic [1:0] KIND_CHAIN = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] fault_address;
    } t_item;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [PAGE_W-1:0]   page_index;
        logic                last;
    } t_result;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] page;
    } t_cmd;

    // Front-to-back command channel
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

    // Back-to-result-queue channel
    typedef struct packed {
        logic    push;
        t_result data;
    } t_res_chan;

    // Page count in use, saturated to the tracked pages
    function automatic logic [CNT_W-1:0] pages_in_use(
        input logic [REGION_PAGES_W-1:0] n
    );
        logic [CNT_W-1:0] r;
        if (n > REGION_PAGES_W'(PAGES)) begin
            r = CNT_W'(PAGES);
        end else begin
            r = CNT_W'(n);
        end
        return r;
    endfunction

endpackage

### sv/dpft_front.sv
module dpft_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  dpft_pkg::t_item             i_item,
    input  logic [dpft_pkg::ADDR_W-1:0] i_region_base,
    input  logic [dpft_pkg::CNT_W-1:0]  i_used,
    output dpft_pkg::t_cmd_chan         o_chan,
    input  logic                        i_take
);
    import dpft_pkg::*;

    t_cmd              r_q [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wp, r_rp;
    logic [CQ_CNT_W-1:0] r_cnt;

    logic [ADDR_W-1:0] off;
    logic              in_region;
    t_cmd              cls;
    logic              do_push;
    logic              do_pop;

    // Classify: flush, fault on a tracked page, or chain
    always_comb begin
        off       = i_item.fault_address - i_region_base;
        in_region = (i_item.fault_address != '0)
                 && (i_item.fault_address >= i_region_base)
                 && ((off >> PAGE_SHIFT) < ADDR_W'(i_used));
        cls.page  = off[PAGE_SHIFT +: IDX_W];
        if (i_item.cmd == CMD_FLUSH) begin
            cls.kind = KIND_FLUSH;
        end else if (in_region) begin
            cls.kind = KIND_FAULT;
        end else begin
            cls.kind = KIND_CHAIN;
        end
    end

    assign o_full       = (r_cnt == CQ_CNT_W'(CQ_DEPTH));
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_take && (r_cnt != '0);
    assign o_chan.valid = (r_cnt != '0);
    assign o_chan.cmd   = r_q[r_rp];

    // Command queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CQ_CNT_W'(do_push) - CQ_CNT_W'(do_pop);
        end
    end

    // Command queue storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

### sv/dpft_back.sv
module dpft_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dpft_pkg::t_cmd_chan        i_chan,
    output logic                       o_take,
    input  logic [dpft_pkg::CNT_W-1:0] i_used,
    output dpft_pkg::t_res_chan        o_res,
    input  logic                       i_res_full
);
    import dpft_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_walk, n_walk;
    logic [PAGES-1:0] r_res, n_res;
    logic [PAGES-1:0] r_wr, n_wr;
    logic [PAGES-1:0] r_dirty, n_dirty;

    logic [IDX_W-1:0] fp;
    logic [IDX_W-1:0] wp;

    assign fp = i_chan.cmd.page;
    assign wp = r_walk[IDX_W-1:0];

    // Fault handling and flush walk
    always_comb begin
        n_state    = r_state;
        n_walk     = r_walk;
        n_res      = r_res;
        n_wr       = r_wr;
        n_dirty    = r_dirty;
        o_take     = 1'b0;
        o_res.push = 1'b0;
        o_res.data = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_chan.valid && !i_res_full) begin
                    o_take = 1'b1;
                    case (i_chan.cmd.kind)
                        KIND_FAULT: begin
                            o_res.push            = 1'b1;
                            o_res.data.last       = 1'b1;
                            if (!r_res[fp]) begin
                                n_res[fp]             = 1'b1;
                                n_wr[fp]              = 1'b0;
                                o_res.data.action     = ACT_FETCH;
                                o_res.data.page_index = PAGE_W'(fp);
                            end else if (!r_wr[fp]) begin
                                n_wr[fp]              = 1'b1;
                                n_dirty[fp]           = 1'b1;
                                o_res.data.action     = ACT_GRANT;
                                o_res.data.page_index = PAGE_W'(fp);
                            end else begin
                                o_res.data.action     = ACT_CHAIN;
                            end
                        end
                        KIND_FLUSH: begin
                            n_state = ST_WALK;
                            n_walk  = '0;
                        end
                        default: begin
                            o_res.push        = 1'b1;
                            o_res.data.action = ACT_CHAIN;
                            o_res.data.last   = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (r_walk == i_used) begin
                    // end of walk: done marker
                    if (!i_res_full) begin
                        o_res.push        = 1'b1;
                        o_res.data.action = ACT_DONE;
                        o_res.data.last   = 1'b1;
                        n_state           = ST_IDLE;
                    end
                end else if (r_res[wp] && r_dirty[wp]) begin
                    if (!i_res_full) begin
                        o_res.push            = 1'b1;
                        o_res.data.action     = ACT_WRITEBACK;
                        o_res.data.page_index = PAGE_W'(wp);
                        n_dirty[wp]           = 1'b0;
                        n_walk                = r_walk + 1'b1;
                    end
                end else begin
                    n_walk = r_walk + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and page flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_walk  <= '0;
            r_res   <= '0;
            r_wr    <= '0;
            r_dirty <= '0;
        end else begin
            r_state <= n_state;
            r_walk  <= n_walk;
            r_res   <= n_res;
            r_wr    <= n_wr;
            r_dirty <= n_dirty;
        end
    end

endmodule

### sv/dpft_resq.sv
module dpft_resq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dpft_pkg::t_res_chan i_res,
    output logic                o_full,
    output logic                o_empty,
    input  logic                i_pop,
    output dpft_pkg::t_result   o_result
);
    import dpft_pkg::*;

    t_result             r_q [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_wp, r_rp;
    logic [RQ_CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full   = (r_cnt == RQ_CNT_W'(RQ_DEPTH));
    assign o_empty  = (r_cnt == '0);
    assign do_push  = i_res.push && !o_full;
    assign do_pop   = i_pop && !o_empty;
    assign o_result = r_q[r_rp];

    // Result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + RQ_CNT_W'(do_push) - RQ_CNT_W'(do_pop);
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_res.data;
        end
    end

endmodule

### sv/demand_page_fault_tracker.sv
// Demand-paging page tracker. Keeps resident/writable/dirty marks for up to
// 32 pages of 4 KiB starting at region_base. Push a fault (cmd 0) and one
// result comes back: fetch, grant write or chain, with last set. Push a flush
// (cmd 1) and a write-back result comes back for each resident dirty page in
// ascending order, then a done result with last set. A fault is one flag
// read-modify-write in the back end. A flush takes the command, steps the
// walk sequencer over each page in use and then pushes the done result. A
// full result queue stalls the back end whenever it has a result to push. A
// two-entry command queue lets faults be accepted while a flush walks. A
// command passes through the command queue register and then the result
// queue register before its first result is on the result ports and can be
// popped. Configuration writes apply immediately and must only be issued while
// no transaction is outstanding.
module demand_page_fault_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  dpft_pkg::t_item                i_item,
    output logic                           empty,
    input  logic                           pop,
    output dpft_pkg::t_result              o_result,
    input  logic                           i_cfg_we,
    input  logic [dpft_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dpft_pkg::ADDR_W-1:0]    i_cfg_data
);
    import dpft_pkg::*;

    logic [ADDR_W-1:0]         r_region_base;
    logic [REGION_PAGES_W-1:0] r_region_pages;
    logic [CNT_W-1:0]          used;

    t_cmd_chan cmd_chan;
    logic      cmd_take;
    t_res_chan res_chan;
    logic      res_full;

    assign used = pages_in_use(r_region_pages);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base  <= '0;
            r_region_pages <= REGION_PAGES_W'(PAGES);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_REGION_BASE:  r_region_base  <= i_cfg_data;
                REG_REGION_PAGES: r_region_pages <= i_cfg_data[REGION_PAGES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dpft_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_item        (i_item),
        .i_region_base (r_region_base),
        .i_used        (used),
        .o_chan        (cmd_chan),
        .i_take        (cmd_take)
    );

    dpft_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_chan     (cmd_chan),
        .o_take     (cmd_take),
        .i_used     (used),
        .o_res      (res_chan),
        .i_res_full (res_full)
    );

    dpft_resq u_resq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (res_chan),
        .o_full   (res_full),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

    // Back end never pushes into a full result queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_chan.push |-> !res_full)
        else $error("result pushed while result queue full");

    // Back end only takes a command that is present
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_chan.valid)
        else $error("command taken from empty queue");

    // Chain and done results carry page zero and have last set
    a_zero_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.action == ACT_CHAIN || o_result.action == ACT_DONE))
        |-> (o_result.page_index == '0) && o_result.last)
        else $error("chain/done result with nonzero page or no last");

endmodule

### test/dpft_monitor.sv
`timescale 1ns / 1ps

// Watches the fault/flush input queue, the result queue and the register
// port, keeps its own copy of the page marks and checks every result.
module dpft_monitor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_full,
    input  dpft_pkg::t_item                i_item,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  dpft_pkg::t_result              i_result,
    input  logic                           i_cfg_we,
    input  logic [dpft_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dpft_pkg::ADDR_W-1:0]    i_cfg_data,
    output int                             o_pending,
    output int                             o_errors
);
    import dpft_pkg::*;

    // Page marks and region setup as the block should hold them
    logic [PAGES-1:0]          resident;
    logic [PAGES-1:0]          writable;
    logic [PAGES-1:0]          dirty;
    logic [ADDR_W-1:0]         region_base;
    logic [REGION_PAGES_W-1:0] region_pages;

    // Actions still owed by the block, oldest first
    t_result owed_actions[$];
    int      mismatches = 0;

    function automatic t_result make_action(input logic [ACTION_W-1:0] act,
                                            input int page, input logic fin);
        t_result r;
        r.action     = act;
        r.page_index = PAGE_W'(page);
        r.last       = fin;
        return r;
    endfunction

    function automatic int active_pages();
        return (region_pages > PAGES) ? PAGES : int'(region_pages);
    endfunction

    // Fault: fetch a missing page, grant write on a read-only one, else chain
    task automatic resolve_fault(input logic [ADDR_W-1:0] addr);
        longint unsigned offset;
        longint unsigned span;
        int              page;
        t_result         act;
        act  = make_action(ACT_CHAIN, 0, 1'b1);
        span = longint'(active_pages()) * PAGE_BYTES;
        if (addr != '0 && addr >= region_base) begin
            offset = longint'(addr) - longint'(region_base);
            if (offset < span) begin
                page = int'(offset / PAGE_BYTES);
                if (!resident[page]) begin
                    resident[page] = 1'b1;
                    writable[page] = 1'b0;
                    act = make_action(ACT_FETCH, page, 1'b1);
                end else if (!writable[page]) begin
                    writable[page] = 1'b1;
                    dirty[page]    = 1'b1;
                    act = make_action(ACT_GRANT, page, 1'b1);
                end
            end
        end
        owed_actions.push_back(act);
    endtask

    // Flush: write back each resident dirty page in order, then done
    task automatic resolve_flush();
        int used;
        used = active_pages();
        for (int p = 0; p < used; p++) begin
            if (resident[p] && dirty[p]) begin
                owed_actions.push_back(make_action(ACT_WRITEBACK, p, 1'b0));
                dirty[p] = 1'b0;
            end
        end
        owed_actions.push_back(make_action(ACT_DONE, 0, 1'b1));
    endtask

    always @(posedge i_clk) begin : observe
        t_result want;
        if (!i_rst_n) begin
            resident     = '0;
            writable     = '0;
            dirty        = '0;
            region_base  = '0;
            region_pages = REGION_PAGES_W'(PAGES);
            owed_actions.delete();
        end else begin
            // Result side first, so a same-edge input never masks a stray result
            if (i_pop && !i_empty) begin
                if (owed_actions.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected result: expected none,", $time,
                             " got action %0d page %0d last %0d",
                             i_result.action, i_result.page_index, i_result.last);
                end else begin
                    want = owed_actions.pop_front();
                    if (i_result.action !== want.action
                            || i_result.page_index !== want.page_index
                            || i_result.last !== want.last) begin
                        mismatches++;
                        $display("%0t ns: result mismatch:", $time,
                                 " expected action %0d page %0d last %0d,",
                                 want.action, want.page_index, want.last,
                                 " got action %0d page %0d last %0d",
                                 i_result.action, i_result.page_index,
                                 i_result.last);
                    end
                end
            end
            // Input transaction
            if (i_push && !i_full) begin
                if (i_item.cmd == CMD_FLUSH) begin
                    resolve_flush();
                end else begin
                    resolve_fault(i_item.fault_address);
                end
            end
            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_REGION_BASE: begin
                        region_base = i_cfg_data;
                    end
                    REG_REGION_PAGES: begin
                        region_pages = i_cfg_data[REGION_PAGES_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending <= owed_actions.size();
        o_errors  <= mismatches;
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dpft_pkg::*;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic                 full;
    t_item                item      = '0;
    logic                 empty;
    logic                 pop       = 1'b0;
    t_result              result;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data  = '0;
    int                   pending;
    int                   errors;

    // Stimulus-side view of the region, used only to aim addresses
    logic [ADDR_W-1:0] cur_base  = '0;
    int                cur_pages = 32;
    int                hot_page  = 0;
    bit                push_steady = 1'b0;
    bit                pop_steady  = 1'b0;
    int                pop_hold    = 0;
    int                pop_gap;

    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    demand_page_fault_tracker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_item      (item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    dpft_monitor monitor (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_item      (item),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_result    (result),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always #4 clk = ~clk;

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side: random stall before each pop, with stall-free stretches
    always @(posedge clk) begin
        if ($urandom_range(0, 63) == 0) begin
            pop_steady <= ~pop_steady;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            pop      <= 1'b0;
            pop_hold <= 0;
        end else if (pop && !empty) begin
            pop_gap = pop_steady ? 0 : $urandom_range(0, 14);
            if (pop_gap != 0) begin
                pop      <= 1'b0;
                pop_hold <= pop_gap - 1;
            end
        end else if (!pop) begin
            if (pop_hold == 0) begin
                pop <= 1'b1;
            end else begin
                pop_hold <= pop_hold - 1;
            end
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    // One input transaction, after a random idle gap
    task automatic send(input logic cmd, input logic [ADDR_W-1:0] addr);
        int gap;
        if ($urandom_range(0, 15) == 0) begin
            push_steady = ~push_steady;
        end
        gap = push_steady ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= '{cmd: cmd, fault_address: addr};
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    // Stop sending and let every owed result drain
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic program_region(input logic [ADDR_W-1:0] base, input int pages);
        cfg_we    <= 1'b1;
        cfg_index <= REG_REGION_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= REG_REGION_PAGES;
        cfg_data  <= ADDR_W'(pages);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_base  = base;
        cur_pages = pages;
    endtask

    // Mostly addresses inside the region, hitting recent pages again so
    // fetch turns into grant; the rest lands just outside or anywhere
    function automatic logic [ADDR_W-1:0] pick_fault_address();
        int              used;
        int              sel;
        longint unsigned a;
        used = (cur_pages > PAGES) ? PAGES : cur_pages;
        sel  = $urandom_range(0, 15);
        if (used != 0 && sel < 11) begin
            if (sel >= 4 || hot_page >= used) begin
                hot_page = $urandom_range(0, used - 1);
            end
            a = longint'(cur_base) + longint'(hot_page) * PAGE_BYTES
                + $urandom_range(0, PAGE_BYTES - 1);
        end else if (sel == 11) begin
            a = longint'(cur_base) - 1 - $urandom_range(0, 2 * PAGE_BYTES);
        end else if (sel == 12) begin
            a = longint'(cur_base) + longint'(used) * PAGE_BYTES
                + $urandom_range(0, 2 * PAGE_BYTES);
        end else if (sel == 13) begin
            a = 0;
        end else begin
            a = longint'(rand_addr());
        end
        return a[ADDR_W-1:0];
    endfunction

    initial begin
        logic [ADDR_W-1:0] base;
        int                pages;
        int                sel;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default region: base 0, 32 pages
        send(CMD_FAULT, '0);                        // null address chains
        send(CMD_FAULT, 48'h1000);                  // fetch page 1
        send(CMD_FAULT, 48'h1FFF);                  // grant page 1
        send(CMD_FAULT, 48'h1800);                  // already writable: chain
        send(CMD_FAULT, 48'h1FFFF);                 // last page
        send(CMD_FAULT, 48'h1F000);
        send(CMD_FAULT, 48'h20000);                 // one past the region
        send(CMD_FAULT, ADDR_MAX);
        send(CMD_FLUSH, rand_addr());               // two write-backs
        send(CMD_FLUSH, ADDR_MAX);                  // nothing dirty left
        send(CMD_FAULT, 48'h1);

        // Region at the very top of the address space
        wait_idle();
        program_region(ADDR_MAX, 32);
        send(CMD_FAULT, ADDR_MAX);
        send(CMD_FAULT, ADDR_MAX - 1);
        send(CMD_FLUSH, '0);

        // No pages in use
        wait_idle();
        program_region(48'h8000_0000_0000, 0);
        send(CMD_FAULT, 48'h8000_0000_0000);
        send(CMD_FLUSH, rand_addr());

        // Page count above the tracked pages saturates
        wait_idle();
        program_region(48'h1000, 63);
        send(CMD_FAULT, 48'h1000 + 31 * PAGE_BYTES);
        send(CMD_FAULT, 48'h1000 + 2 * PAGE_BYTES + 5);
        send(CMD_FAULT, 48'h1000 + 32 * PAGE_BYTES);

        // Single page at address zero
        wait_idle();
        program_region('0, 1);
        send(CMD_FAULT, 48'hFFF);
        send(CMD_FAULT, 48'h1000);
        send(CMD_FLUSH, '0);

        // Random phases, each with its own region setup
        for (int phase = 0; phase < 5; phase++) begin
            sel = $urandom_range(0, 5);
            case (sel)
                0: base = '0;
                1: base = rand_addr();
                2: base = ADDR_MAX - $urandom_range(0, 40 * PAGE_BYTES);
                default: base = rand_addr() & ~ADDR_W'(PAGE_BYTES - 1);
            endcase
            sel = $urandom_range(0, 11);
            if (sel < 8) begin
                pages = $urandom_range(1, 32);
            end else if (sel == 8) begin
                pages = 1;
            end else if (sel == 9) begin
                pages = 32;
            end else if (sel == 10) begin
                pages = 0;
            end else begin
                pages = $urandom_range(33, 63);
            end
            wait_idle();
            program_region(base, pages);
            for (int n = 0; n < 20; n++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send(CMD_FLUSH, rand_addr());
                end else begin
                    send(CMD_FAULT, pick_fault_address());
                end
            end
            send(CMD_FLUSH, rand_addr());
        end

        wait_idle();
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
sv/dpft_pkg.sv
sv/dpft_front.sv
sv/dpft_back.sv
sv/dpft_resq.sv
sv/demand_page_fault_tracker.sv
test/dpft_monitor.sv
test/testbench.sv
